// File: rtl/core/rar_pkg.sv
package rar_pkg;

	localparam int unsigned OPERAND_WIDTH_DEF = 32;
	localparam int unsigned MAG_W = 64;
	localparam int unsigned CNT_W = 7;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	// Control that the sequencer hands to the divider cell row.
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

// File: rtl/core/rar_div_cell.sv
// One bit of the restoring divider: a slice of the partial remainder and the
// quotient/dividend shift register. Each cell passes its top bits to the next.
module rar_div_cell (
	input  logic clk,
	input  logic ld,
	input  logic stp,
	input  logic init_bit,
	input  logic rem_in,
	input  logic quo_in,
	input  logic d_bit,
	input  logic borrow_in,
	input  logic sub_en,
	output logic rem_bit,
	output logic quo_bit,
	output logic diff_bit,
	output logic borrow_out
);
	logic rem_q;
	logic quo_q;

	// Trial subtraction of the divisor bit from the shifted remainder bit.
	assign diff_bit   = rem_in ^ d_bit ^ borrow_in;
	assign borrow_out = (~rem_in & d_bit) | (~(rem_in ^ d_bit) & borrow_in);
	assign rem_bit    = rem_q;
	assign quo_bit    = quo_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			rem_q <= 1'b0;
			quo_q <= init_bit;
		end else if (stp) begin
			rem_q <= sub_en ? diff_bit : rem_in;
			quo_q <= quo_in;
		end
	end
endmodule

// File: rtl/core/rar_divider.sv
// Bit-serial unsigned divider built from a chain of identical cells.
module rar_divider (
	input  logic                     clk,
	input  rar_pkg::div_ctl_t        ctl,
	input  logic [rar_pkg::MAG_W-1:0] dividend,
	input  logic [rar_pkg::MAG_W-1:0] divisor,
	output logic [rar_pkg::MAG_W-1:0] quotient,
	output logic [rar_pkg::MAG_W-1:0] remainder
);
	import rar_pkg::*;

	logic [MAG_W-1:0] rem_v;
	logic [MAG_W-1:0] quo_v;
	logic [MAG_W-1:0] diff_v;
	logic [MAG_W:0]   brw;
	logic [MAG_W-1:0] rem_sh;
	logic [MAG_W-1:0] quo_sh;
	logic             keep;

	// Shifted remainder takes the dividend's top bit; quotient bits enter at LSB.
	assign rem_sh = {rem_v[MAG_W-2:0], quo_v[MAG_W-1]};
	assign brw[0] = 1'b0;
	// The subtraction fits when a bit was shifted out of the top or no borrow leaves it.
	assign keep   = rem_v[MAG_W-1] | ~brw[MAG_W];
	assign quo_sh = {quo_v[MAG_W-2:0], keep};

	for (genvar i = 0; i < MAG_W; i++) begin : g_cell
		rar_div_cell u_cell (
			.clk       (clk),
			.ld        (ctl.load),
			.stp       (ctl.step),
			.init_bit  (dividend[i]),
			.rem_in    (rem_sh[i]),
			.quo_in    (quo_sh[i]),
			.d_bit     (divisor[i]),
			.borrow_in (brw[i]),
			.sub_en    (keep),
			.rem_bit   (rem_v[i]),
			.quo_bit   (quo_v[i]),
			.diff_bit  (diff_v[i]),
			.borrow_out(brw[i+1])
		);
	end

	assign quotient  = quo_v;
	assign remainder = rem_v;
	logic unused_diff;
	assign unused_diff = ^diff_v;
endmodule

// File: rtl/core/rational_arith_reduce_unit.sv
// Sequence: the product steps, the sum, one divider pass per Euclid step, the final
// divisions of numerator and denominator by the gcd, and the done state; res_valid is
// registered from the done state. The 64-cell divider chain gives one quotient bit per cycle.
// An item with a zero denominator or a zero divisor fraction goes straight to the done state.
// Throughput: one item at a time; busy falls in the cycle that res_valid is high.
// Reset: arst_n clears the sequencer and the strobe; data registers are not reset.
module rational_arith_reduce_unit #(
	parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic signed [31:0]         a_num,
	input  logic signed [31:0]         a_den,
	input  logic signed [31:0]         b_num,
	input  logic signed [31:0]         b_den,
	output logic                       res_valid,
	output logic signed [63:0]         res_num,
	output logic [62:0]                res_den,
	output logic                       err
);
	import rar_pkg::*;

	localparam int unsigned PW = 2 * OPERAND_WIDTH;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	opcode_t          op_q;
	logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [63:0] p_q, q_q, d_q;
	logic [MAG_W-1:0]   nmag_q, dmag_q, x_q, y_q, g_q;
	logic               neg_q;
	logic               valid_q;
	logic signed [63:0] num_out_q;
	logic [62:0]        den_out_q;
	logic               err_q;

	div_ctl_t         dctl;
	logic [MAG_W-1:0] dvd, dvs, quo, rem;

	// Operands are cut to the configured width.
	logic signed [OPERAND_WIDTH-1:0] an_w, ad_w, bn_w, bd_w;
	assign an_w = a_num[OPERAND_WIDTH-1:0];
	assign ad_w = a_den[OPERAND_WIDTH-1:0];
	assign bn_w = b_num[OPERAND_WIDTH-1:0];
	assign bd_w = b_den[OPERAND_WIDTH-1:0];

	logic in_err;
	assign in_err = (ad_w == '0) || (bd_w == '0) ||
		((opcode_t'(opcode) == OP_DIV) && (bn_w == '0));

	// Sum of the two products on sign and magnitude; multiply and divide pass the first product alone.
	logic signed [63:0] q_eff, s_w;
	logic [MAG_W-1:0]   pm, qm, sum_mag;
	logic               sum_neg;
	always_comb begin
		q_eff = (op_q == OP_SUB) ? -q_q : q_q;
		s_w   = p_q + q_eff;
		pm    = p_q[63] ? (64'd0 - p_q) : p_q;
		qm    = q_eff[63] ? (64'd0 - q_eff) : q_eff;
		if (op_q == OP_MUL || op_q == OP_DIV) begin
			sum_mag = pm;
			sum_neg = p_q[63];
		end else if (!p_q[63] && !q_eff[63]) begin
			sum_mag = pm + qm;
			sum_neg = 1'b0;
		end else if (p_q[63] && q_eff[63]) begin
			sum_mag = pm + qm;
			sum_neg = 1'b1;
		end else begin
			sum_mag = s_w[63] ? (64'd0 - s_w) : s_w;
			sum_neg = s_w[63];
		end
	end

	// The divider has finished all 64 steps when the count reaches 65.
	logic last_bit;
	assign last_bit = (cnt_q == CNT_W'(MAG_W + 1));

	always_comb begin
		dvd = x_q;
		dvs = y_q;
		unique case (state_q)
			ST_DIVN: begin dvd = nmag_q; dvs = g_q; end
			ST_DIVD: begin dvd = dmag_q; dvs = g_q; end
			default: begin dvd = x_q; dvs = y_q; end
		endcase
	end

	rar_divider u_div (
		.clk      (clk),
		.ctl      (dctl),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.remainder(rem)
	);

	// Sequencer: cnt 0 loads the divider, counts 1..64 shift bits, and at count 65
	// the quotient and remainder are taken.
	always_comb begin
		state_d   = state_q;
		dctl.load = 1'b0;
		dctl.step = 1'b0;
		unique case (state_q)
			ST_IDLE: if (start) state_d = in_err ? ST_DONE : ST_MUL;
			ST_MUL:  if (cnt_q == CNT_W'(1)) state_d = ST_SUM;
			ST_SUM:  state_d = ST_GCD;
			ST_GCD, ST_DIVN, ST_DIVD: begin
				if (state_q == ST_GCD && y_q == '0) begin
					state_d = ST_DIVN;
				end else begin
					dctl.load = (cnt_q == '0);
					dctl.step = (cnt_q != '0) && !last_bit;
					if (last_bit && state_q == ST_DIVN) state_d = ST_DIVD;
					if (last_bit && state_q == ST_DIVD) state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_DONE);
			if (state_d != state_q || state_q == ST_IDLE || state_q == ST_SUM ||
				(state_q == ST_GCD && y_q == '0))
				cnt_q <= '0;
			else if (last_bit)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				op_q  <= opcode_t'(opcode);
				an_q  <= an_w; ad_q <= ad_w; bn_q <= bn_w; bd_q <= bd_w;
				err_q <= in_err;
			end
			ST_MUL: begin
				// The numerator and denominator products are formed at count 0,
				// the cross product for a sum at count 1.
				if (cnt_q == '0) begin
					p_q <= 64'(an_q * ((op_q == OP_MUL) ? bn_q : bd_q));
					d_q <= 64'(ad_q * ((op_q == OP_DIV) ? bn_q : bd_q));
				end else begin
					q_q <= 64'(bn_q * ad_q);
				end
			end
			ST_SUM: begin
				nmag_q <= sum_mag;
				neg_q  <= sum_neg ^ d_q[63];
				dmag_q <= d_q[63] ? (64'd0 - d_q) : d_q;
				x_q    <= sum_mag;
				y_q    <= d_q[63] ? (64'd0 - d_q) : d_q;
			end
			ST_GCD: begin
				if (y_q == '0) g_q <= x_q;
				else if (last_bit) begin
					x_q <= y_q;
					y_q <= rem;
				end
			end
			ST_DIVN: if (last_bit) nmag_q <= quo;
			ST_DIVD: if (last_bit) dmag_q <= quo;
			ST_DONE: begin
				if (err_q) begin
					num_out_q <= '0;
					den_out_q <= '0;
				end else if (nmag_q == '0) begin
					num_out_q <= '0;
					den_out_q <= 63'd1;
				end else if (neg_q) begin
					num_out_q <= (nmag_q > {1'b1, 63'd0}) ? {1'b1, 63'd0} : (64'd0 - nmag_q);
					den_out_q <= dmag_q[62:0];
				end else begin
					num_out_q <= nmag_q[63] ? {1'b0, {63{1'b1}}} : nmag_q;
					den_out_q <= dmag_q[62:0];
				end
			end
			default: ;
		endcase
	end

	logic unused_w;
	assign unused_w = ^PW;

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = valid_q;
	assign res_num   = num_out_q;
	assign res_den   = den_out_q;
	assign err       = err_q;
endmodule

// File: sim/rational_arith_reduce_unit_test.sv
module rational_arith_reduce_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rar_pkg::*;

	// One fraction operation and the reduced fraction that it gives.
	typedef struct {
		opcode_t          op;
		logic signed [31:0] an;
		logic signed [31:0] ad;
		logic signed [31:0] bn;
		logic signed [31:0] bd;
	} frac_op_t;

	typedef struct {
		logic signed [63:0] num;
		logic [62:0]        den;
		logic               err;
	} frac_res_t;

	// A directed row: the operation, and optionally a result read off at a glance.
	typedef struct {
		frac_op_t  item;
		bit        fixed;
		frac_res_t res;
	} directed_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic signed [31:0] b_den;
	logic               res_valid;
	logic signed [63:0] res_num;
	logic [62:0]        res_den;
	logic               err;

	frac_res_t pending_fracs[$];
	int        fail_count = 0;

	localparam logic signed [31:0] SMIN = 32'sh8000_0000;
	localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;

	rational_arith_reduce_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_valid(res_valid), .res_num(res_num), .res_den(res_den), .err(err)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Plain Euclid on magnitudes.
	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Computes the reduced fraction. Products of 32-bit operands fit in 64 bits;
	// the cross sum is taken at 66 bits so it cannot wrap.
	function automatic frac_res_t reduce_fraction(frac_op_t f);
		frac_res_t          r;
		logic signed [65:0] nsum;
		logic signed [65:0] dprod;
		logic [65:0]        nmag;
		logic [65:0]        dmag;
		logic [63:0]        g;
		logic               neg;
		r.num = '0;
		r.den = '0;
		r.err = 1'b0;
		if (f.ad == 0 || f.bd == 0 || (f.op == OP_DIV && f.bn == 0)) begin
			r.err = 1'b1;
			return r;
		end
		case (f.op)
			OP_ADD: begin
				nsum = 66'(f.an) * 66'(f.bd) + 66'(f.bn) * 66'(f.ad);
				dprod = 66'(f.ad) * 66'(f.bd);
			end
			OP_SUB: begin
				nsum = 66'(f.an) * 66'(f.bd) - 66'(f.bn) * 66'(f.ad);
				dprod = 66'(f.ad) * 66'(f.bd);
			end
			OP_MUL: begin
				nsum = 66'(f.an) * 66'(f.bn);
				dprod = 66'(f.ad) * 66'(f.bd);
			end
			default: begin
				nsum = 66'(f.an) * 66'(f.bd);
				dprod = 66'(f.ad) * 66'(f.bn);
			end
		endcase
		neg = (nsum < 0) ^ (dprod < 0);
		nmag = nsum < 0 ? -nsum : nsum;
		dmag = dprod < 0 ? -dprod : dprod;
		if (nmag == 0) begin
			r.den = 63'd1;
			return r;
		end
		g = euclid_gcd(nmag[63:0], dmag[63:0]);
		nmag = nmag / g;
		dmag = dmag / g;
		// Saturation cannot trigger at 32-bit operands but is kept for width changes.
		if (neg) begin
			if (nmag > 66'h0_8000_0000_0000_0000)
				nmag = 66'h0_8000_0000_0000_0000;
			r.num = -nmag[63:0];
		end else begin
			if (nmag > 66'h0_7fff_ffff_ffff_ffff)
				nmag = 66'h0_7fff_ffff_ffff_ffff;
			r.num = nmag[63:0];
		end
		r.den = dmag[62:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45)
			return 0;
		if (k < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Random operand: mostly small values with shared factors, sometimes full width.
	function automatic logic signed [31:0] rand_operand();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return $signed($urandom_range(0, 40)) - 20;
		if (k < 6)
			return ($signed($urandom_range(0, 200)) - 100) * ($urandom_range(1, 6) * 6);
		if (k == 6)
			return $urandom_range(0, 1) ? SMIN : SMAX;
		return $signed($urandom());
	endfunction

	// Drives one item at the falling edge and holds it until the block takes it.
	task automatic send_fraction_op(frac_op_t f, bit fixed, frac_res_t res);
		@(negedge clk);
		start <= 1'b1;
		opcode <= f.op;
		a_num <= f.an;
		a_den <= f.ad;
		b_num <= f.bn;
		b_den <= f.bd;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_fracs.push_back(fixed ? res : reduce_fraction(f));
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Every result is checked field by field against the oldest expectation.
	always @(posedge clk) begin
		frac_res_t want;
		if (arst_n && res_valid) begin
			if (pending_fracs.size() == 0) begin
				$display("%0t: result with nothing expected: %0d/%0d err %0b",
					$realtime, res_num, res_den, err);
				fail_count++;
			end else begin
				want = pending_fracs.pop_front();
				if (res_num !== want.num) begin
					$display("%0t: res_num expected %0d actual %0d", $realtime, want.num, res_num);
					fail_count++;
				end
				if (res_den !== want.den) begin
					$display("%0t: res_den expected %0d actual %0d", $realtime, want.den, res_den);
					fail_count++;
				end
				if (err !== want.err) begin
					$display("%0t: err expected %0b actual %0b", $realtime, want.err, err);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#400ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		directed_row_t rows[$];
		frac_op_t      f;
		frac_res_t     none;
		frac_res_t     error_res;
		frac_res_t     zero_res;
		int            n;
		int            drain;

		none = '{num: '0, den: '0, err: 1'b0};
		error_res = '{num: '0, den: '0, err: 1'b1};
		zero_res = '{num: '0, den: 63'd1, err: 1'b0};

		start = 1'b0;
		opcode = OP_ADD;
		a_num = '0;
		a_den = 32'sd1;
		b_num = '0;
		b_den = 32'sd1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Errors, zero numerators, small hand-worked results, and the extremes of the operand range.
		rows.push_back('{'{OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1}, 1, error_res});
		rows.push_back('{'{OP_SUB, 32'sd1, 32'sd1, 32'sd1, 32'sd0}, 1, error_res});
		rows.push_back('{'{OP_MUL, SMAX, 32'sd0, SMIN, 32'sd0}, 1, error_res});
		rows.push_back('{'{OP_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd5}, 1, error_res});
		rows.push_back('{'{OP_DIV, 32'sd0, 32'sd4, 32'sd0, 32'sd5}, 1, error_res});
		rows.push_back('{'{OP_ADD, 32'sd0, 32'sd7, 32'sd0, -32'sd9}, 1, zero_res});
		rows.push_back('{'{OP_SUB, 32'sd3, 32'sd4, 32'sd3, 32'sd4}, 1, zero_res});
		rows.push_back('{'{OP_MUL, 32'sd0, SMIN, SMAX, SMIN}, 1, zero_res});
		rows.push_back('{'{OP_DIV, 32'sd0, 32'sd1, 32'sd5, 32'sd1}, 1, zero_res});
		rows.push_back('{'{OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3}, 1,
			'{num: 64'sd5, den: 63'd6, err: 1'b0}});
		rows.push_back('{'{OP_MUL, 32'sd2, -32'sd4, 32'sd3, 32'sd9}, 1,
			'{num: -64'sd1, den: 63'd6, err: 1'b0}});
		rows.push_back('{'{OP_DIV, 32'sd1, 32'sd2, 32'sd1, 32'sd4}, 1,
			'{num: 64'sd2, den: 63'd1, err: 1'b0}});
		rows.push_back('{'{OP_ADD, SMAX, 32'sd1, SMAX, 32'sd1}, 0, none});
		rows.push_back('{'{OP_SUB, SMIN, 32'sd1, SMAX, 32'sd1}, 0, none});
		rows.push_back('{'{OP_ADD, SMIN, SMAX, SMIN, SMAX}, 0, none});
		rows.push_back('{'{OP_SUB, SMIN, -32'sd1, SMAX, SMIN}, 0, none});
		rows.push_back('{'{OP_MUL, SMIN, 32'sd1, SMIN, 32'sd1}, 0, none});
		rows.push_back('{'{OP_MUL, SMIN, SMAX, SMAX, SMIN}, 0, none});
		rows.push_back('{'{OP_DIV, SMIN, -32'sd1, SMIN, 32'sd1}, 0, none});
		rows.push_back('{'{OP_DIV, SMAX, SMIN, -32'sd1, SMAX}, 0, none});
		rows.push_back('{'{OP_ADD, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 0, none});
		rows.push_back('{'{OP_DIV, 32'sd6, -32'sd4, -32'sd9, 32'sd2}, 0, none});
		rows.push_back('{'{OP_SUB, 32'sd5, 32'sd12, -32'sd7, 32'sd18}, 0, none});

		foreach (rows[i])
			send_fraction_op(rows[i].item, rows[i].fixed, rows[i].res);

		// Random part: random gaps, plus a few full drains between items.
		for (n = 0; n < 1280; n++) begin
			repeat (pick_gap()) @(negedge clk);
			if (n % 300 == 150)
				wait (pending_fracs.size() == 0);
			f.op = opcode_t'($urandom_range(0, 3));
			f.an = rand_operand();
			f.ad = $urandom_range(0, 30) == 0 ? 32'sd0 : rand_operand();
			f.bn = rand_operand();
			f.bd = $urandom_range(0, 30) == 0 ? 32'sd0 : rand_operand();
			send_fraction_op(f, 0, none);
		end

		// Wait for the last results, then watch on for a stray strobe.
		drain = 0;
		while (pending_fracs.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_fracs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
